@@ rtl/lps_pkg.sv @@
// Shared types and constants of the line pixel stepper.
// Holds coordinate widths, the command encoding and the queued command record.
// Used by lps_front, lps_queue, lps_back and line_pixel_stepper_core.
package lps_pkg;

  localparam int CoordBits    = 12;
  localparam int DeltaBits    = CoordBits + 1;
  localparam int ErrBits      = CoordBits + 3;
  localparam int ColorBits    = 32;

  localparam int InFieldBits  = 4 * CoordBits + ColorBits;
  localparam int InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int OutFieldBits = 2 * CoordBits + ColorBits;
  localparam int OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);
  localparam int QueueCntBits = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    FuncStart   = 1'b0,
    FuncAdvance = 1'b1
  } func_e;

  // Decoded command as it travels from the front end to the stepper.
  typedef struct packed {
    logic                        is_start;
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic        [DeltaBits-1:0] abs_dx;
    logic signed [DeltaBits-1:0] neg_dy;
    logic                        step_x_neg;
    logic                        step_y_neg;
    logic signed [ErrBits-1:0]   err_init;
    logic        [ColorBits-1:0] color;
  } cmd_t;

endpackage

@@ rtl/lps_front.sv @@
// Front end of the line pixel stepper: accepts stream transactions and decodes them.
// Computes deltas, step signs and the initial error term for start commands.
// Depends on lps_pkg.
module lps_front (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_func_i,
  input  logic [lps_pkg::InDataBits-1:0] in_data_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output lps_pkg::cmd_t                cmd_o
);
  import lps_pkg::*;

  logic signed [CoordBits-1:0] sx, sy, ex, ey;
  logic signed [DeltaBits-1:0] ddx, ddy;
  logic        [DeltaBits-1:0] abs_dx;
  logic signed [DeltaBits-1:0] neg_dy;
  func_e                       func;

  always_comb begin
    func = func_e'(in_func_i);
    sx   = in_data_i[CoordBits-1:0];
    sy   = in_data_i[2*CoordBits-1:CoordBits];
    ex   = in_data_i[3*CoordBits-1:2*CoordBits];
    ey   = in_data_i[4*CoordBits-1:3*CoordBits];

    ddx    = {ex[CoordBits-1], ex} - {sx[CoordBits-1], sx};
    ddy    = {ey[CoordBits-1], ey} - {sy[CoordBits-1], sy};
    abs_dx = ddx[DeltaBits-1] ? DeltaBits'(-ddx) : DeltaBits'(ddx);
    neg_dy = ddy[DeltaBits-1] ? ddy : -ddy;

    cmd_o.is_start   = (func == FuncStart);
    cmd_o.start_x    = sx;
    cmd_o.start_y    = sy;
    cmd_o.end_x      = ex;
    cmd_o.end_y      = ey;
    cmd_o.abs_dx     = abs_dx;
    cmd_o.neg_dy     = neg_dy;
    cmd_o.step_x_neg = ddx[DeltaBits-1];
    cmd_o.step_y_neg = ddy[DeltaBits-1];
    cmd_o.err_init   = $signed({2'b00, abs_dx})
                     + $signed({{2{neg_dy[DeltaBits-1]}}, neg_dy});
    cmd_o.color      = in_data_i[InFieldBits-1:4*CoordBits];
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

@@ rtl/lps_queue.sv @@
// Short command queue between the front end and the stepper.
// Register-based FIFO of decoded commands; depth from lps_pkg.
// Depends on lps_pkg.
module lps_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_valid_i,
  output logic                            push_ready_o,
  input  lps_pkg::cmd_t                   push_cmd_i,
  output logic                            pop_valid_o,
  input  logic                            pop_ready_i,
  output lps_pkg::cmd_t                   pop_cmd_o,
  output logic [lps_pkg::QueueCntBits-1:0] count_o
);
  import lps_pkg::*;

  cmd_t                    entries_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntBits-1:0] count_q, count_d;
  logic                    push, pop;

  always_comb begin
    push_ready_o = (count_q != QueueCntBits'(QueueDepth));
    pop_valid_o  = (count_q != '0);
    push         = push_valid_i && push_ready_o;
    pop          = pop_ready_i && pop_valid_o;
    wr_ptr_d     = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d      = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  assign pop_cmd_o = entries_q[rd_ptr_q];
  assign count_o   = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/lps_back.sv @@
// Back end of the line pixel stepper: holds the line state and walks it.
// Steps x, y or both per advance command and drives the registered pixel output.
// Depends on lps_pkg.
module lps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  lps_pkg::cmd_t                 cmd_i,
  output logic                          pix_valid_o,
  input  logic                          pix_ready_i,
  output logic [lps_pkg::CoordBits-1:0] pix_x_o,
  output logic [lps_pkg::CoordBits-1:0] pix_y_o,
  output logic [lps_pkg::ColorBits-1:0] pix_color_o,
  output logic                          pix_last_o,
  output logic                          busy_o
);
  import lps_pkg::*;

  // Line state
  logic signed [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CoordBits-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic        [DeltaBits-1:0] abs_dx_q, abs_dx_d;
  logic signed [DeltaBits-1:0] neg_dy_q, neg_dy_d;
  logic                        sxn_q, sxn_d, syn_q, syn_d;
  logic signed [ErrBits-1:0]   err_q, err_d;
  logic        [ColorBits-1:0] color_q, color_d;
  logic                        busy_q, busy_d;

  // Output register
  logic                        out_valid_q, out_valid_d;
  logic        [CoordBits-1:0] out_x_q, out_y_q;
  logic        [ColorBits-1:0] out_color_q;
  logic                        out_last_q, last;

  logic                        pop, emit, step_x, step_y;
  logic signed [ErrBits:0]     e2, err_sum;

  always_comb begin
    cmd_ready_o = !out_valid_q || pix_ready_i;
    pop         = cmd_valid_i && cmd_ready_o;

    e2     = {err_q, 1'b0};
    step_x = e2 >= $signed({{3{neg_dy_q[DeltaBits-1]}}, neg_dy_q});
    step_y = e2 <= $signed({3'b000, abs_dx_q});
    err_sum = {err_q[ErrBits-1], err_q}
            + (step_x ? $signed({{3{neg_dy_q[DeltaBits-1]}}, neg_dy_q}) : '0)
            + (step_y ? $signed({3'b000, abs_dx_q}) : '0);

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    tgt_x_d  = tgt_x_q;
    tgt_y_d  = tgt_y_q;
    abs_dx_d = abs_dx_q;
    neg_dy_d = neg_dy_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    err_d    = err_q;
    color_d  = color_q;
    emit     = 1'b0;

    if (pop) begin
      if (cmd_i.is_start) begin
        // Load a new line; any line in flight is dropped.
        cur_x_d  = cmd_i.start_x;
        cur_y_d  = cmd_i.start_y;
        tgt_x_d  = cmd_i.end_x;
        tgt_y_d  = cmd_i.end_y;
        abs_dx_d = cmd_i.abs_dx;
        neg_dy_d = cmd_i.neg_dy;
        sxn_d    = cmd_i.step_x_neg;
        syn_d    = cmd_i.step_y_neg;
        err_d    = cmd_i.err_init;
        color_d  = cmd_i.color;
        emit     = 1'b1;
      end else if (busy_q) begin
        if (step_x) begin
          cur_x_d = cur_x_q + (sxn_q ? {CoordBits{1'b1}} : CoordBits'(1));
        end
        if (step_y) begin
          cur_y_d = cur_y_q + (syn_q ? {CoordBits{1'b1}} : CoordBits'(1));
        end
        err_d = err_sum[ErrBits-1:0];
        emit  = 1'b1;
      end
    end

    last        = (cur_x_d == tgt_x_d) && (cur_y_d == tgt_y_d);
    busy_d      = emit ? !last : busy_q;
    out_valid_d = emit ? 1'b1 : (pix_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    tgt_x_q  <= tgt_x_d;
    tgt_y_q  <= tgt_y_d;
    abs_dx_q <= abs_dx_d;
    neg_dy_q <= neg_dy_d;
    sxn_q    <= sxn_d;
    syn_q    <= syn_d;
    err_q    <= err_d;
    color_q  <= color_d;
    if (emit) begin
      out_x_q     <= cur_x_d;
      out_y_q     <= cur_y_d;
      out_color_q <= color_d;
      out_last_q  <= last;
    end
  end

  assign pix_valid_o = out_valid_q;
  assign pix_x_o     = out_x_q;
  assign pix_y_o     = out_y_q;
  assign pix_color_o = out_color_q;
  assign pix_last_o  = out_last_q;
  assign busy_o      = busy_q;

endmodule

@@ rtl/line_pixel_stepper_core.sv @@
// Top level of the line pixel stepper: front end, command queue and stepper.
// Depends on lps_pkg, lps_front, lps_queue and lps_back.
// Exposes one input stream of commands and one output stream of pixels.

// All-octant Bresenham line stepper. Each input transaction is one command:
// tuser = 0 starts a line from (start_x, start_y) to (end_x, end_y) in the
// given color and emits its first pixel; tuser = 1 advances one pixel along
// the current line and emits it. The pixel that equals the end point comes
// out with tlast set, after which the stepper is idle and advance commands
// are consumed without producing a pixel. A start command while a line is
// in progress abandons that line. While the pixel output is not stalled,
// the block sustains one command and one pixel per cycle: the front end
// decodes a command in the cycle it is taken, a four-entry queue decouples
// it from the stepper, and the stepper's combinational error update feeds a
// registered pixel output behind the queue register. The input keeps
// accepting while a pixel waits on the output until the queue is full.
module line_pixel_stepper_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: start_x[11:0], start_y[11:0], end_x[11:0], end_y[11:0],
  // pixel_color[31:0]
  input  logic [lps_pkg::InDataBits-1:0]  s_axis_tdata,
  // tuser: func (0 = start line, 1 = advance)
  input  logic                            s_axis_tuser,
  // Pixel stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: pixel_x[11:0], pixel_y[11:0], out_color[31:0]
  output logic [lps_pkg::OutDataBits-1:0] m_axis_tdata,
  // tlast: last_pixel
  output logic                            m_axis_tlast
);
  import lps_pkg::*;

  cmd_t                    front_cmd, back_cmd;
  logic                    front_valid, front_ready;
  logic                    back_valid, back_ready;
  logic [QueueCntBits-1:0] queue_count;
  logic [CoordBits-1:0]    pix_x, pix_y;
  logic [ColorBits-1:0]    pix_color;
  logic                    busy;

  // Decode each command transaction as it arrives.
  lps_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_func_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Buffer decoded commands so that a stalled pixel output does not stall input until the queue is full.
  lps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd),
    .count_o      (queue_count)
  );

  // Walk the line and hold each pixel until the sink takes it.
  lps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .pix_valid_o (m_axis_tvalid),
    .pix_ready_i (m_axis_tready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_last_o  (m_axis_tlast),
    .busy_o      (busy)
  );

  // Pack the pixel fields; they fill tdata exactly, with no pad bits.
  assign m_axis_tdata = OutDataBits'({pix_color, pix_y, pix_x});

`ifndef SYNTHESIS
  // A pending pixel and the line state agree: only the end pixel leaves the stepper idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (busy == !m_axis_tlast))
    else $error("stepper busy flag disagrees with pending pixel's tlast");

  // The queue never holds more commands than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_count <= QueueCntBits'(QueueDepth))
    else $error("command queue overfilled");

  // A full queue must refuse further command transactions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_count == QueueCntBits'(QueueDepth)) && s_axis_tvalid && !back_ready
      |=> queue_count == QueueCntBits'(QueueDepth))
    else $error("command queue changed while full and stalled");
`endif

endmodule

@@ dv/line_pixel_stepper_core_tb.sv @@
// Testbench for line_pixel_stepper_core: sends start and advance commands, walks
// each line with its own Bresenham stepper and checks every pixel that comes out.
// Depends on lps_pkg and line_pixel_stepper_core.
module line_pixel_stepper_core_tb;
  import lps_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int CalmTail  = 60;
  localparam int LineItems = 400;
  localparam int CoordMin  = -(1 << (CoordBits - 1));
  localparam int CoordMax  = (1 << (CoordBits - 1)) - 1;

  typedef struct {
    func_e                       op;
    logic signed [CoordBits-1:0] x0;
    logic signed [CoordBits-1:0] y0;
    logic signed [CoordBits-1:0] x1;
    logic signed [CoordBits-1:0] y1;
    logic        [ColorBits-1:0] color;
  } line_cmd_t;

  typedef struct {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic        [ColorBits-1:0] color;
    logic                        last;
  } pixel_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  line_cmd_t cmd_backlog[$];
  pixel_t    pixels_due[$];
  int        errors      = 0;
  bit        random_part = 1'b0;
  int        tx_gap      = 0;
  int        tx_smooth   = 0;
  int        rx_gap      = 0;
  int        rx_smooth   = 0;
  int        idle_cycles = 0;

  // Line walker state, zero at start; the walker starts idle like the block after reset.
  logic signed [CoordBits-1:0] walk_x      = '0;
  logic signed [CoordBits-1:0] walk_y      = '0;
  logic signed [CoordBits-1:0] goal_x      = '0;
  logic signed [CoordBits-1:0] goal_y      = '0;
  logic        [DeltaBits-1:0] span_x      = '0;
  logic signed [DeltaBits-1:0] rise_neg    = '0;
  logic                        left_step   = 1'b0;
  logic                        down_step   = 1'b0;
  logic signed [ErrBits-1:0]   walk_err    = '0;
  logic        [ColorBits-1:0] walk_color  = '0;
  logic                        walk_active = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  line_pixel_stepper_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Advance the walker by one accepted command and queue the pixel it yields.
  task automatic walk_pixel(input line_cmd_t c);
    int     ddx;
    int     ddy;
    int     e2;
    int     acc;
    pixel_t px;
    if (c.op == FuncStart) begin
      ddx        = int'(c.x1) - int'(c.x0);
      ddy        = int'(c.y1) - int'(c.y0);
      walk_x     = c.x0;
      walk_y     = c.y0;
      goal_x     = c.x1;
      goal_y     = c.y1;
      span_x     = DeltaBits'((ddx < 0) ? -ddx : ddx);
      rise_neg   = DeltaBits'((ddy < 0) ? ddy : -ddy);
      left_step  = c.x1 < c.x0;
      down_step  = c.y1 < c.y0;
      walk_err   = ErrBits'(int'(span_x) + int'(rise_neg));
      walk_color = c.color;
    end else begin
      if (!walk_active) return;
      // Test both steps on the same doubled error.
      e2  = 2 * int'(walk_err);
      acc = int'(walk_err);
      if (e2 >= int'(rise_neg)) begin
        acc    = acc + int'(rise_neg);
        walk_x = CoordBits'(int'(walk_x) + (left_step ? -1 : 1));
      end
      if (e2 <= int'(span_x)) begin
        acc    = acc + int'(span_x);
        walk_y = CoordBits'(int'(walk_y) + (down_step ? -1 : 1));
      end
      walk_err = ErrBits'(acc);
    end
    px.x        = walk_x;
    px.y        = walk_y;
    px.color    = walk_color;
    px.last     = (walk_x == goal_x) && (walk_y == goal_y);
    walk_active = !px.last;
    pixels_due.push_back(px);
  endtask

  function automatic bit calm_tail();
    return random_part && (cmd_backlog.size() < CalmTail);
  endfunction

  function automatic int clamp_coord(int v);
    if (v > CoordMax) return CoordMax;
    if (v < CoordMin) return CoordMin;
    return v;
  endfunction

  // Favor the edges of the coordinate range a quarter of the time each.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return CoordMin + int'($urandom_range(0, 7));
    if (r == 1) return CoordMax - int'($urandom_range(0, 7));
    return int'($urandom_range(0, CoordMax - CoordMin)) + CoordMin;
  endfunction

  task automatic push_start(input int x0, input int y0, input int x1, input int y1,
                            input logic [ColorBits-1:0] color);
    line_cmd_t c;
    c.op    = FuncStart;
    c.x0    = CoordBits'(x0);
    c.y0    = CoordBits'(y0);
    c.x1    = CoordBits'(x1);
    c.y1    = CoordBits'(y1);
    c.color = color;
    cmd_backlog.push_back(c);
  endtask

  // Advance commands carry random payload that the block must ignore.
  task automatic push_advance(input int count);
    line_cmd_t c;
    repeat (count) begin
      c.op    = FuncAdvance;
      c.x0    = CoordBits'($urandom);
      c.y0    = CoordBits'($urandom);
      c.x1    = CoordBits'($urandom);
      c.y1    = CoordBits'($urandom);
      c.color = $urandom;
      cmd_backlog.push_back(c);
    end
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endfunction

  // Command driver: hold a transaction until taken, insert idle bursts between.
  always @(posedge clk_i or negedge rst_ni) begin
    bit present;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        walk_pixel(cmd_backlog.pop_front());
      end
      present = s_axis_tvalid && !s_axis_tready;
      if (!present) begin
        if (tx_smooth > 0) begin
          tx_smooth--;
        end else if ($urandom_range(0, 29) == 0) begin
          tx_smooth = $urandom_range(20, 60);
        end
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!calm_tail() && tx_smooth == 0 && $urandom_range(0, 4) == 0) begin
          tx_gap = $urandom_range(0, 4);
        end else begin
          present = cmd_backlog.size() > 0;
        end
      end
      if (present) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd_backlog[0].op;
        s_axis_tdata  <= {cmd_backlog[0].color, cmd_backlog[0].y1, cmd_backlog[0].x1,
                          cmd_backlog[0].y0, cmd_backlog[0].x0};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Pixel monitor and ready stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=0x%0h last=%0b",
                   $time, $signed(m_axis_tdata[CoordBits-1:0]),
                   $signed(m_axis_tdata[2*CoordBits-1:CoordBits]),
                   m_axis_tdata[2*CoordBits+ColorBits-1:2*CoordBits], m_axis_tlast);
        end else begin
          want = pixels_due.pop_front();
          check_field("pixel_x", want.x, $signed(m_axis_tdata[CoordBits-1:0]));
          check_field("pixel_y", want.y, $signed(m_axis_tdata[2*CoordBits-1:CoordBits]));
          check_field("out_color", want.color,
                      m_axis_tdata[2*CoordBits+ColorBits-1:2*CoordBits]);
          check_field("last_pixel", want.last, m_axis_tlast);
        end
      end
      if (rx_smooth > 0) begin
        rx_smooth--;
      end else if ($urandom_range(0, 29) == 0) begin
        rx_smooth = $urandom_range(20, 60);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm_tail() && rx_smooth == 0 && $urandom_range(0, 4) == 0) begin
        rx_gap = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL line_pixel_stepper_core");
        $finish;
      end
    end
  end

  initial begin
    int made;
    int kind;
    int ax;
    int ay;
    int bx;
    int by;
    int len;
    int steps;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle advances, a zero-length line, corner-to-corner lines
    // abandoned mid-walk, and short lines in several octants.
    push_advance(1);
    push_start(CoordMax, CoordMin, CoordMax, CoordMin, 32'hFFFF_FFFF);
    push_advance(1);
    push_start(CoordMin, CoordMin, CoordMax, CoordMax, 32'h0000_0000);
    push_advance(2);
    push_start(CoordMax, CoordMax, CoordMin, CoordMin, 32'hA5A5_5A5A);
    push_advance(2);
    push_start(0, 0, 3, -1, 32'h1234_5678);
    push_advance(4);
    push_start(0, 0, -1, 3, 32'h8765_4321);
    push_advance(3);
    push_start(5, 5, 5, 3, 32'h0F0F_F0F0);
    push_advance(2);
    push_start(-7, 4, -9, 4, 32'hDEAD_BEEF);
    push_advance(2);

    // Hold further commands until every pixel of the directed part is back.
    while (cmd_backlog.size() != 0 || pixels_due.size() != 0) @(posedge clk_i);

    // Random: mostly short lines walked to the end, some long lines walked
    // partly, some walks cut short, and stray advance commands.
    random_part = 1'b1;
    made = 0;
    while (made < LineItems) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        push_advance($urandom_range(1, 3));
      end else if (kind == 1) begin
        steps = $urandom_range(5, 30);
        push_start(pick_coord(), pick_coord(), pick_coord(), pick_coord(), $urandom);
        push_advance(steps);
        made += 1 + steps;
      end else begin
        ax  = pick_coord();
        ay  = pick_coord();
        bx  = clamp_coord(ax + int'($urandom_range(0, 30)) - 15);
        by  = clamp_coord(ay + int'($urandom_range(0, 30)) - 15);
        len = (bx > ax) ? bx - ax : ax - bx;
        if (((by > ay) ? by - ay : ay - by) > len) len = (by > ay) ? by - ay : ay - by;
        steps = len;
        if ($urandom_range(0, 7) == 0) steps = $urandom_range(0, len);
        push_start(ax, ay, bx, by, $urandom);
        push_advance(steps);
        made += 1 + steps;
      end
    end

    while (cmd_backlog.size() != 0 || pixels_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pixels_due.size() == 0) begin
      $display("PASS line_pixel_stepper_core");
    end else begin
      $display("FAIL line_pixel_stepper_core");
    end
    $finish;
  end

endmodule

@@ line_pixel_stepper_core.f @@
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_queue.sv
rtl/lps_back.sv
rtl/line_pixel_stepper_core.sv
dv/line_pixel_stepper_core_tb.sv
